FILE: src/rhc_pkg.sv
`default_nettype none

package rhc_pkg;

    // Default configuration
    localparam int CHANNEL_BITS_DEF  = 8;
    localparam int HUE_FRAC_BITS_DEF = 6;

    // Fixed field widths of the result word
    localparam int HUE_OUT_BITS    = 15;
    localparam int SAT_OUT_BITS    = 8;
    localparam int BRIGHT_OUT_BITS = 8;
    localparam int M_TDATA_BITS    = 32;

    // Which channel is the maximum (priority red, green, blue)
    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } hue_sel_t;

endpackage

`default_nettype wire

FILE: src/rhc_div_pipe.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Expects dividend[top DIV_BITS] < divisor. Stages past QUOT_BITS pass through.
module rhc_div_pipe #(
    parameter int DIV_BITS  = rhc_pkg::CHANNEL_BITS_DEF,
    parameter int QUOT_BITS = rhc_pkg::CHANNEL_BITS_DEF,
    parameter int STAGES    = rhc_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic [STAGES-1:0]             en,
    input  wire logic [DIV_BITS+QUOT_BITS-1:0] dividend,
    input  wire logic [DIV_BITS-1:0]           divisor,
    output logic      [QUOT_BITS-1:0]          quotient
);

    logic [DIV_BITS-1:0]  rem_reg  [STAGES];
    logic [QUOT_BITS-1:0] low_reg  [STAGES];
    logic [QUOT_BITS-1:0] quo_reg  [STAGES];
    logic [DIV_BITS-1:0]  dvs_reg  [STAGES];

    logic [DIV_BITS-1:0]  rem_next [STAGES];
    logic [QUOT_BITS-1:0] low_next [STAGES];
    logic [QUOT_BITS-1:0] quo_next [STAGES];
    logic [DIV_BITS-1:0]  dvs_next [STAGES];

    always_comb begin
        logic [DIV_BITS-1:0]  rem_s;
        logic [QUOT_BITS-1:0] low_s;
        logic [QUOT_BITS-1:0] quo_s;
        logic [DIV_BITS-1:0]  dvs_s;
        logic [DIV_BITS+1:0]  trial;
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                rem_s = dividend[DIV_BITS+QUOT_BITS-1:QUOT_BITS];
                low_s = dividend[QUOT_BITS-1:0];
                quo_s = '0;
                dvs_s = divisor;
            end else begin
                rem_s = rem_reg[k-1];
                low_s = low_reg[k-1];
                quo_s = quo_reg[k-1];
                dvs_s = dvs_reg[k-1];
            end
            trial = {1'b0, rem_s, low_s[QUOT_BITS-1]} - {2'b00, dvs_s};
            if (k < QUOT_BITS) begin
                // borrow set: keep shifted remainder
                rem_next[k] = trial[DIV_BITS+1] ? {rem_s[DIV_BITS-2:0], low_s[QUOT_BITS-1]}
                                                : trial[DIV_BITS-1:0];
                low_next[k] = {low_s[QUOT_BITS-2:0], 1'b0};
                quo_next[k] = {quo_s[QUOT_BITS-2:0], ~trial[DIV_BITS+1]};
            end else begin
                rem_next[k] = rem_s;
                low_next[k] = low_s;
                quo_next[k] = quo_s;
            end
            dvs_next[k] = dvs_s;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (en[k]) begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
                dvs_reg[k] <= dvs_next[k];
            end
        end
    end

    assign quotient = quo_reg[STAGES-1];

endmodule

`default_nettype wire

FILE: src/rgb_to_hsv_converter.sv
`default_nettype none

// Channel  Dir  Ports                          Word contents (low bit up)
// s_       in   s_tvalid s_tready s_tdata      red, green, blue (CHANNEL_BITS each)
// m_       out  m_tvalid m_tready m_tdata      hue[14:0], saturation[7:0], brightness[7:0]
//                             m_tuser          hue_undefined
//
// One pixel per clock sustained while m_tready is high. The pipeline runs stage A,
// stage B, the divider stages and the final stage; its depth is set by the two
// restoring dividers, one quotient bit per stage, running side by side.
// aresetn (sync, active low) clears only the stage valid bits.
// Each stage holds when its successor is full and stalled, so bubbles are
// squeezed out; the input stalls only once every stage holds a word.
module rgb_to_hsv_converter #(
    parameter int CHANNEL_BITS  = rhc_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // red, green, blue from bit 0 up, zero padded to bytes
    input  wire logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // hue[14:0], saturation[22:15], brightness[30:23], bit 31 zero
    output logic [rhc_pkg::M_TDATA_BITS-1:0]         m_tdata,
    // hue_undefined
    output logic [0:0]                               m_tuser
);

    localparam int W      = CHANNEL_BITS;
    localparam int F      = HUE_FRAC_BITS;
    localparam int QH     = 6 + F;                      // hue quotient bits (60 < 64)
    localparam int S      = (W > QH) ? W : QH;          // divider stages
    localparam int T      = S + 3;                      // all stages
    localparam int HBITS  = 9 + F;                      // holds 360 degrees
    localparam int HW     = (HBITS > rhc_pkg::HUE_OUT_BITS) ? HBITS : rhc_pkg::HUE_OUT_BITS;
    localparam int OW     = (W > 8) ? W : 8;
    localparam logic [QH-1:0] HUE_SIXTH = QH'(60 << F);
    localparam logic [HW-1:0] HUE_FULL  = HW'(360 << F);

    typedef struct packed {
        logic [W-1:0]      bright;
        logic              undef;
        rhc_pkg::hue_sel_t sel;
        logic              neg;
    } side_t;

    // ---------------- stage handshake ----------------
    logic [T-1:0] valid_reg;
    logic [T-1:0] en;

    // A stage loads when empty or when its successor loads.
    always_comb begin
        en[T-1] = !valid_reg[T-1] || m_tready;
        for (int i = T - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < T; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= (i == 0) ? s_tvalid : valid_reg[i-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[T-1];

    // ---------------- stage A: max, min, difference ----------------
    logic [W-1:0]      a_hi_reg, a_span_reg, a_mag_reg;
    logic              a_neg_reg;
    rhc_pkg::hue_sel_t a_sel_reg;

    logic [W-1:0]      a_hi_next, a_span_next, a_mag_next;
    logic              a_neg_next;
    rhc_pkg::hue_sel_t a_sel_next;

    always_comb begin
        logic [W-1:0] r, g, b, lo;
        logic [W:0]   diff;
        logic [W:0]   mag_wide;
        r = s_tdata[W-1:0];
        g = s_tdata[2*W-1:W];
        b = s_tdata[3*W-1:2*W];
        a_hi_next = r;
        if (g > a_hi_next) a_hi_next = g;
        if (b > a_hi_next) a_hi_next = b;
        lo = r;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        a_span_next = a_hi_next - lo;
        if (r == a_hi_next) begin
            a_sel_next = rhc_pkg::SEL_RED;
            diff       = {1'b0, g} - {1'b0, b};
        end else if (g == a_hi_next) begin
            a_sel_next = rhc_pkg::SEL_GREEN;
            diff       = {1'b0, b} - {1'b0, r};
        end else begin
            a_sel_next = rhc_pkg::SEL_BLUE;
            diff       = {1'b0, r} - {1'b0, g};
        end
        a_neg_next = diff[W];
        mag_wide   = a_neg_next ? (~diff + 1'b1) : diff;
        a_mag_next = mag_wide[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_hi_reg   <= a_hi_next;
            a_span_reg <= a_span_next;
            a_mag_reg  <= a_mag_next;
            a_neg_reg  <= a_neg_next;
            a_sel_reg  <= a_sel_next;
        end
    end

    // ---------------- stage B: dividends ----------------
    logic [2*W-1:0]  b_sat_dvd_reg;
    logic [W+QH-1:0] b_hue_dvd_reg;
    logic [W-1:0]    b_span_reg;
    side_t           b_side_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            // span * (2^W - 1)
            b_sat_dvd_reg     <= {a_span_reg, {W{1'b0}}} - {{W{1'b0}}, a_span_reg};
            b_hue_dvd_reg     <= (W+QH)'(a_mag_reg) * (W+QH)'(HUE_SIXTH);
            b_span_reg        <= a_span_reg;
            b_side_reg.bright <= a_hi_reg;
            b_side_reg.undef  <= (a_span_reg == '0);   // black implies zero span
            b_side_reg.sel    <= a_sel_reg;
            b_side_reg.neg    <= a_neg_reg;
        end
    end

    // ---------------- divider stages ----------------
    logic [W-1:0]  sat_quo;
    logic [QH-1:0] hue_quo;
    side_t         side_reg [S];

    rhc_div_pipe #(
        .DIV_BITS  (W),
        .QUOT_BITS (W),
        .STAGES    (S)
    ) u_sat_div (
        .aclk     (aclk),
        .en       (en[S+1:2]),
        .dividend (b_sat_dvd_reg),
        .divisor  (b_side_reg.bright),
        .quotient (sat_quo)
    );

    rhc_div_pipe #(
        .DIV_BITS  (W),
        .QUOT_BITS (QH),
        .STAGES    (S)
    ) u_hue_div (
        .aclk     (aclk),
        .en       (en[S+1:2]),
        .dividend (b_hue_dvd_reg),
        .divisor  (b_span_reg),
        .quotient (hue_quo)
    );

    always_ff @(posedge aclk) begin
        for (int k = 0; k < S; k++) begin
            if (en[2+k]) begin
                side_reg[k] <= (k == 0) ? b_side_reg : side_reg[k-1];
            end
        end
    end

    // ---------------- final stage: offset, sign, wrap ----------------
    logic [HW-1:0] hue_reg, hue_next;
    logic [W-1:0]  sat_reg;
    logic [W-1:0]  bright_reg;
    logic          undef_reg;

    always_comb begin
        logic [HW-1:0] q;
        logic [HW-1:0] offset;
        side_t         sd;
        sd = side_reg[S-1];
        q  = HW'(hue_quo);
        unique case (sd.sel)
            rhc_pkg::SEL_RED:   offset = '0;
            rhc_pkg::SEL_GREEN: offset = HW'(2) * HW'(HUE_SIXTH);
            rhc_pkg::SEL_BLUE:  offset = HW'(4) * HW'(HUE_SIXTH);
            default:            offset = '0;
        endcase
        if (sd.undef) begin
            hue_next = '0;
        end else if (sd.neg) begin
            // red sector below zero wraps to the top of the circle
            if (sd.sel == rhc_pkg::SEL_RED) begin
                hue_next = (q == '0) ? '0 : HUE_FULL - q;
            end else begin
                hue_next = offset - q;
            end
        end else begin
            hue_next = offset + q;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[T-1]) begin
            hue_reg    <= hue_next;
            sat_reg    <= side_reg[S-1].undef ? '0 : sat_quo;
            bright_reg <= side_reg[S-1].bright;
            undef_reg  <= side_reg[S-1].undef;
        end
    end

    logic [OW-1:0] sat_ext, bright_ext;
    assign sat_ext    = OW'(sat_reg);
    assign bright_ext = OW'(bright_reg);

    assign m_tdata = {1'b0, bright_ext[7:0], sat_ext[7:0], hue_reg[rhc_pkg::HUE_OUT_BITS-1:0]};
    assign m_tuser = undef_reg;

    // ---------------- assertions ----------------
    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && undef_reg |-> hue_reg == '0 && sat_reg == '0)
        else $error("undefined hue with nonzero hue or saturation");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> hue_reg < HUE_FULL)
        else $error("hue beyond full circle");

    a_sat_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !undef_reg |-> sat_reg != '0)
        else $error("colored pixel with zero saturation");

    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready && (&valid_reg))
        else $error("input held off with room in the pipeline");

endmodule

`default_nettype wire
